// File: rtl/smt_pkg.sv
package smt_pkg;

  // Default number of table slots
  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes; the unused code behaves as a lookup
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

endpackage

// File: rtl/smt_ram.sv
module smt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/set_membership_table.sv
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid / s_tready  s_tuser = mode, s_tdata = value
// m_*      out  m_tvalid / m_tready  m_tdata = hit, status, count
//
// For each request a scan reads one slot a cycle from the value RAM (one port,
// registered read), compares it and tracks the lowest free slot, then the done
// state applies the write-back and loads the result.
// s_tready is high only while idle. The result register holds until taken;
// a finished request waits in write-back while an earlier result stalls.
// rst clears valid marks, count and control at once; slot values need none.
module set_membership_table
  import smt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] hit, [2:1] status, [7:3] count
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  state_t state, state_next;

  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;
  logic [IW-1:0]      scan_idx;
  logic               cmp_en;
  logic [IW-1:0]      cmp_idx;
  logic               found;
  logic [IW-1:0]      match_idx;
  logic               have_free;
  logic [IW-1:0]      free_idx;
  logic [CAPACITY-1:0] slot_valid;
  logic [CW-1:0]      element_count;

  logic [VALUE_W-1:0] rd_data;
  logic               ram_we;
  logic [IW-1:0]      ram_addr;
  logic               cmp_hit;
  logic               cmp_free;
  logic               in_beat;
  logic               out_free;
  logic               do_insert;
  logic               do_remove;
  logic [STATUS_W-1:0] status;
  logic [CW-1:0]      count_after;
  logic [CW+COUNT_W-1:0] count_ext;

  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Compare the slot read last cycle
  assign cmp_hit  = cmp_en && slot_valid[cmp_idx] && (rd_data == value);
  assign cmp_free = cmp_en && !slot_valid[cmp_idx];

  // Decide the operation once the scan is over
  assign do_insert = (mode == MODE_INSERT) && !found && have_free;
  assign do_remove = (mode == MODE_REMOVE) && found;

  always_comb begin
    status      = ST_DONE;
    count_after = element_count;
    if (mode == MODE_INSERT) begin
      if (found) begin
        status = ST_DUP;
      end else if (!have_free) begin
        status = ST_FULL;
      end else begin
        count_after = element_count + CW'(1);
      end
    end else if (mode == MODE_REMOVE) begin
      if (found) begin
        count_after = element_count - CW'(1);
      end else begin
        status = ST_ABSENT;
      end
    end
  end

  assign count_ext = (CW + COUNT_W)'(count_after);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_SCAN;
      S_SCAN: if (scan_idx == LAST_IDX) state_next = S_LAST;
      S_LAST: state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    ram_we   = 1'b0;
    ram_addr = scan_idx;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_SCAN: ram_addr = scan_idx;
      S_LAST: ram_addr = scan_idx;
      S_DONE: begin
        ram_addr = free_idx;
        ram_we   = out_free && do_insert;
      end
      default: s_tready = 1'b0;
    endcase
  end

  smt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value),
    .rdata (rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      element_count <= '0;
      m_tvalid      <= 1'b0;
      cmp_en        <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= (state == S_SCAN);
      if (state == S_DONE && out_free) begin
        m_tvalid      <= 1'b1;
        element_count <= count_after;
        if (do_insert) begin
          slot_valid[free_idx] <= 1'b1;
        end else if (do_remove) begin
          slot_valid[match_idx] <= 1'b0;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request, scan and result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      mode      <= s_tuser;
      value     <= s_tdata;
      scan_idx  <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
    end else begin
      if (state == S_SCAN && scan_idx != LAST_IDX) begin
        scan_idx <= scan_idx + IW'(1);
      end
      if (cmp_hit && !found) begin
        found     <= 1'b1;
        match_idx <= cmp_idx;
      end
      if (cmp_free && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= cmp_idx;
      end
    end
    cmp_idx <= scan_idx;
    if (state == S_DONE && out_free) begin
      m_tdata <= {count_ext[COUNT_W-1:0], status, found};
    end
  end

endmodule

// File: sim/set_membership_checker.sv
module set_membership_checker
  import smt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [0] hit, [2:1] status, [7:3] count
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Laid out as on m_tdata, most significant field first
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
    logic                hit;
  } reply_t;

  // Shadow copy of the table
  logic [VALUE_W-1:0] stored [CAPACITY];
  bit                 held [CAPACITY];
  int unsigned        members;

  reply_t expected_replies [$];

  // Apply one request to the shadow table and return its reply
  function automatic reply_t apply_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
    int     i;
    int     match_idx;
    int     free_idx;
    reply_t r;
    match_idx = -1;
    free_idx  = -1;
    for (i = 0; i < CAPACITY; i++) begin
      if (held[i]) begin
        if (match_idx < 0 && stored[i] == value) match_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    r.hit    = (match_idx >= 0);
    r.status = ST_DONE;
    case (mode)
      MODE_INSERT: begin
        if (r.hit) begin
          r.status = ST_DUP;
        end else if (free_idx < 0) begin
          r.status = ST_FULL;
        end else begin
          stored[free_idx] = value;
          held[free_idx]   = 1'b1;
          members++;
        end
      end
      MODE_REMOVE: begin
        if (r.hit) begin
          held[match_idx] = 1'b0;
          members--;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: ;  // lookup and the spare code leave the table alone
    endcase
    r.count = members[COUNT_W-1:0];
    return r;
  endfunction

  // Compare each result beat, then predict each accepted request beat
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      foreach (held[i]) held[i] = 1'b0;
      members = 0;
      errors  = 0;
      expected_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result beat hit=%0d status=%0d count=%0d",
                   $time, got.hit, got.status, got.count);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (got.hit !== want.hit || got.status !== want.status ||
              got.count !== want.count) begin
            $display("%0t: result mismatch expected hit=%0d status=%0d count=%0d, ",
                     $time, want.hit, want.status, want.count,
                     "got hit=%0d status=%0d count=%0d",
                     got.hit, got.status, got.count);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) expected_replies.push_back(apply_request(s_tuser, s_tdata));
    end
    pending = expected_replies.size();
  end

endmodule

// File: sim/tb_set_membership_table.sv
module tb_set_membership_table;
  import smt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused opcode, decoded as a lookup
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_FROM   = 800;
  localparam int POOL_SIZE    = 24;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] value
  logic [1:0]  s_tuser  = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [0] hit, [2:1] status, [7:3] count

  int fail_count;
  int outstanding;
  int send_gap_pct  = 0;
  int ready_gap_pct = 0;

  logic [31:0] value_pool [POOL_SIZE];

  set_membership_table uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  set_membership_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(fail_count), .pending(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("tb_set_membership_table: FAIL");
    $finish;
  end

  // Stall the result side in bursts of random length
  initial begin
    forever begin
      @(negedge clk);
      if (ready_gap_pct > 0 && $urandom_range(0, 99) < ready_gap_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Present one request beat and hold it until taken; returns on a falling edge
  task automatic send_req(input logic [MODE_W-1:0] mode, input logic [31:0] value);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the request side until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 80) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  initial begin
    int          n;
    int          r;
    int          i;
    bit          fill_phase;
    logic [1:0]  op;

    foreach (value_pool[k]) value_pool[k] = $urandom;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, duplicates, misses, spare opcode, then a full table
    send_req(MODE_INSERT, 32'h8000_0000);
    send_req(MODE_INSERT, 32'h7FFF_FFFF);
    send_req(MODE_INSERT, 32'h0000_0000);
    send_req(MODE_INSERT, 32'hFFFF_FFFF);
    send_req(MODE_INSERT, 32'h7FFF_FFFF);
    send_req(MODE_LOOKUP, 32'hFFFF_FFFF);
    send_req(MODE_LOOKUP, 32'h0000_0005);
    send_req(MODE_SPARE,  32'h0000_0000);
    send_req(MODE_REMOVE, 32'h8000_0000);
    send_req(MODE_REMOVE, 32'h8000_0000);
    send_req(MODE_LOOKUP, 32'h8000_0000);
    send_req(MODE_INSERT, 32'hAAAA_AAAA);
    send_req(MODE_INSERT, 32'h5555_5555);
    for (i = 0; i < 11; i++) send_req(MODE_INSERT, 32'h0000_1000 + i);
    send_req(MODE_INSERT, 32'h1234_5678);
    drain_results();

    // Random: alternate filling and emptying phases over a small value pool
    fill_phase = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        fill_phase    = ~fill_phase;
        send_gap_pct  = (n >= QUIET_FROM) ? 0 : 20 * $urandom_range(0, 2);
        ready_gap_pct = (n >= QUIET_FROM) ? 0 : 20 * $urandom_range(0, 2);
        value_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      r = $urandom_range(0, 99);
      if (fill_phase) begin
        op = (r < 60) ? MODE_INSERT : (r < 80) ? MODE_REMOVE :
             (r < 95) ? MODE_LOOKUP : MODE_SPARE;
      end else begin
        op = (r < 25) ? MODE_INSERT : (r < 70) ? MODE_REMOVE :
             (r < 95) ? MODE_LOOKUP : MODE_SPARE;
      end
      send_req(op, pick_value());
      if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end

    // Wait out the last results and let the bench idle, then report the verdict
    drain_results();
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_set_membership_table: PASS");
    end else begin
      $display("tb_set_membership_table: FAIL");
    end
    $finish;
  end

endmodule
